// ----- sv/dtq_pkg.sv -----
// Shared types and constants for the deadline timer queue.
package dtq_pkg;

    localparam int TIME_W    = 48;
    localparam int TAG_W     = 16;
    localparam int ARG_W     = 32;
    localparam int ENTRY_W   = TIME_W + TAG_W;
    localparam int STATUS_W  = 2;
    localparam int MAX_RESULTS = 32;
    localparam int K_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_SCHEDULED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FIRED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd3;

    // Input kind codes
    localparam logic FUNC_SCHEDULE = 1'b0;
    localparam logic FUNC_ADVANCE  = 1'b1;

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_ADD     = 7'b0000010,
        S_INS_RD  = 7'b0000100,
        S_INS_CMP = 7'b0001000,
        S_ADV_RD  = 7'b0010000,
        S_ADV_CMP = 7'b0100000,
        S_EMIT    = 7'b1000000
    } t_state;

    // One queue entry as stored in the RAM
    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } t_entry;

endpackage

// ----- sv/deadline_timer_queue.sv -----
// Schedule: the sum is formed in S_ADD; a full queue drops the item, else S_INS_RD and S_INS_CMP
// alternate per entry shifted up until the new entry is placed, then one SCHEDULED beat follows.
// Advance: a zero step gives one NONE beat; else entries are read and compared from the front, and
// those strictly past due are popped until a not-due entry ends the scan; each fired result is its own beat.
// One item at a time; output stalls hold the sequencer.
// Reset (i_rst_n low, synchronous) clears time, occupancy and sequencer; RAM is not swept.
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // delay[31:0], tag[47:32], step[79:48]
    input  logic        i_s_tuser,   // func
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // status[1:0], fired_tag[17:2], fired_deadline[65:18], zero
    output logic        o_m_tlast
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SW = AW + 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = dtq_pkg::TIME_W;
    localparam int GW = dtq_pkg::TAG_W;
    localparam int XW = dtq_pkg::ARG_W;
    localparam int EW = dtq_pkg::ENTRY_W;
    localparam int QW = dtq_pkg::STATUS_W;
    localparam int KW = dtq_pkg::K_W;

    // Wrap a sum of pointer and offset back into the ring
    function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(QUEUE_DEPTH)) ? (s - SW'(QUEUE_DEPTH)) : s;
        return t[AW-1:0];
    endfunction

    dtq_pkg::t_state r_state, r_ret;

    // Latched input item
    logic          r_func;
    logic [XW-1:0] r_delay;
    logic [GW-1:0] r_tag;
    logic [XW-1:0] r_step;

    // Time, ring pointers and work registers
    logic [TW-1:0]            r_time;
    logic [TW-1:0]            r_sum;
    logic [AW-1:0]            r_head;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_pos;
    logic [KW-1:0]            r_k;

    // Fired entry waiting to learn whether it is the last beat
    logic          r_pend_valid;
    logic [GW-1:0] r_pend_tag;
    logic [TW-1:0] r_pend_dl;

    // Result staged for the output register
    logic [QW-1:0] r_res_status;
    logic [GW-1:0] r_res_tag;
    logic [TW-1:0] r_res_dl;
    logic          r_res_last;

    // Output register
    logic          r_out_valid;
    logic [QW-1:0] r_out_status;
    logic [GW-1:0] r_out_tag;
    logic [TW-1:0] r_out_dl;
    logic          r_out_last;

    logic                 w_out_free;
    logic [AW-1:0]        w_pos_addr;
    logic [AW-1:0]        w_prev_addr;
    logic [AW-1:0]        w_head_next;
    logic                 w_ram_we;
    logic [AW-1:0]        w_ram_raddr;
    dtq_pkg::t_entry      w_ram_wdata;
    logic [EW-1:0]        w_ram_rdata;
    dtq_pkg::t_entry      w_rd;
    logic [TW-1:0]        w_alu_a, w_alu_b, w_sum;
    logic                 w_lt;
    logic                 w_room;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_pos_addr  = wrap_idx({1'b0, r_head} + {1'b0, r_pos[AW-1:0]});
    assign w_prev_addr = wrap_idx({1'b0, r_head} + {1'b0, AW'(r_pos - 1'b1)});
    assign w_head_next = wrap_idx({1'b0, r_head} + SW'(1));
    assign w_rd        = dtq_pkg::t_entry'(w_ram_rdata);
    assign w_room      = (r_count != '0) && (r_k < KW'(dtq_pkg::MAX_RESULTS));

    assign o_s_tready  = (r_state == dtq_pkg::S_IDLE);

    // Route operands to the shared add/compare unit
    always_comb begin
        unique case (r_state)
            dtq_pkg::S_ADD: begin
                w_alu_a = r_time;
                w_alu_b = {{(TW-XW){1'b0}}, (r_func == dtq_pkg::FUNC_ADVANCE) ? r_step : r_delay};
            end
            dtq_pkg::S_INS_CMP: begin
                w_alu_a = r_sum;
                w_alu_b = w_rd.deadline;
            end
            default: begin
                w_alu_a = w_rd.deadline;
                w_alu_b = r_time;
            end
        endcase
    end

    dtq_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_sum (w_sum),
        .o_lt  (w_lt)
    );

    // RAM write: shift an entry up, or place the new one
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_wdata = '{deadline: r_sum, tag: r_tag};
        w_ram_raddr = r_head;
        if (r_state == dtq_pkg::S_INS_RD) begin
            w_ram_raddr = w_prev_addr;
            w_ram_we    = (r_pos == '0);
        end else if (r_state == dtq_pkg::S_INS_CMP) begin
            w_ram_we = 1'b1;
            if (w_lt) begin
                w_ram_wdata = w_rd;
            end
        end
    end

    dtq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_pos_addr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dtq_pkg::S_IDLE;
            r_ret        <= dtq_pkg::S_IDLE;
            r_time       <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            unique case (r_state)
                dtq_pkg::S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_func  <= i_s_tuser;
                        r_delay <= i_s_tdata[31:0];
                        r_tag   <= i_s_tdata[47:32];
                        r_step  <= i_s_tdata[79:48];
                        r_state <= dtq_pkg::S_ADD;
                    end
                end
                dtq_pkg::S_ADD: begin
                    r_sum <= w_sum;
                    if (r_func == dtq_pkg::FUNC_ADVANCE) begin
                        if (r_step == '0) begin
                            r_res_status <= dtq_pkg::ST_NONE;
                            r_res_tag    <= '0;
                            r_res_dl     <= '0;
                            r_res_last   <= 1'b1;
                            r_ret        <= dtq_pkg::S_IDLE;
                            r_state      <= dtq_pkg::S_EMIT;
                        end else begin
                            r_time       <= w_sum;
                            r_k          <= '0;
                            r_pend_valid <= 1'b0;
                            r_state      <= dtq_pkg::S_ADV_RD;
                        end
                    end else if (r_count == CW'(QUEUE_DEPTH)) begin
                        r_res_status <= dtq_pkg::ST_DROPPED;
                        r_res_tag    <= '0;
                        r_res_dl     <= '0;
                        r_res_last   <= 1'b1;
                        r_ret        <= dtq_pkg::S_IDLE;
                        r_state      <= dtq_pkg::S_EMIT;
                    end else begin
                        r_pos   <= r_count;
                        r_state <= dtq_pkg::S_INS_RD;
                    end
                end
                dtq_pkg::S_INS_RD: begin
                    // At the front: the new entry lands here
                    if (r_pos == '0) begin
                        r_count      <= r_count + 1'b1;
                        r_res_status <= dtq_pkg::ST_SCHEDULED;
                        r_res_tag    <= '0;
                        r_res_dl     <= '0;
                        r_res_last   <= 1'b1;
                        r_ret        <= dtq_pkg::S_IDLE;
                        r_state      <= dtq_pkg::S_EMIT;
                    end else begin
                        r_state <= dtq_pkg::S_INS_CMP;
                    end
                end
                dtq_pkg::S_INS_CMP: begin
                    // Later deadline moves up one slot; otherwise insert behind it
                    if (w_lt) begin
                        r_pos   <= r_pos - 1'b1;
                        r_state <= dtq_pkg::S_INS_RD;
                    end else begin
                        r_count      <= r_count + 1'b1;
                        r_res_status <= dtq_pkg::ST_SCHEDULED;
                        r_res_tag    <= '0;
                        r_res_dl     <= '0;
                        r_res_last   <= 1'b1;
                        r_ret        <= dtq_pkg::S_IDLE;
                        r_state      <= dtq_pkg::S_EMIT;
                    end
                end
                dtq_pkg::S_ADV_RD: begin
                    if (w_room) begin
                        r_state <= dtq_pkg::S_ADV_CMP;
                    end else begin
                        r_res_status <= r_pend_valid ? dtq_pkg::ST_FIRED : dtq_pkg::ST_NONE;
                        r_res_tag    <= r_pend_valid ? r_pend_tag : '0;
                        r_res_dl     <= r_pend_valid ? r_pend_dl : '0;
                        r_res_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_ret        <= dtq_pkg::S_IDLE;
                        r_state      <= dtq_pkg::S_EMIT;
                    end
                end
                dtq_pkg::S_ADV_CMP: begin
                    if (w_lt) begin
                        // Pop the front; release the previous fired entry as a non-last beat
                        r_head       <= w_head_next;
                        r_count      <= r_count - 1'b1;
                        r_k          <= r_k + 1'b1;
                        r_pend_valid <= 1'b1;
                        r_pend_tag   <= w_rd.tag;
                        r_pend_dl    <= w_rd.deadline;
                        if (r_pend_valid) begin
                            r_res_status <= dtq_pkg::ST_FIRED;
                            r_res_tag    <= r_pend_tag;
                            r_res_dl     <= r_pend_dl;
                            r_res_last   <= 1'b0;
                            r_ret        <= dtq_pkg::S_ADV_RD;
                            r_state      <= dtq_pkg::S_EMIT;
                        end else begin
                            r_state <= dtq_pkg::S_ADV_RD;
                        end
                    end else begin
                        r_res_status <= r_pend_valid ? dtq_pkg::ST_FIRED : dtq_pkg::ST_NONE;
                        r_res_tag    <= r_pend_valid ? r_pend_tag : '0;
                        r_res_dl     <= r_pend_valid ? r_pend_dl : '0;
                        r_res_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_ret        <= dtq_pkg::S_IDLE;
                        r_state      <= dtq_pkg::S_EMIT;
                    end
                end
                dtq_pkg::S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= dtq_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Output register: load a staged result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == dtq_pkg::S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dtq_pkg::S_EMIT && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_tag    <= r_res_tag;
            r_out_dl     <= r_res_dl;
            r_out_last   <= r_res_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_dl, r_out_tag, r_out_status};
    assign o_m_tlast  = r_out_last;

    // Occupancy never exceeds the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // Insert work only runs with a free slot
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtq_pkg::S_INS_RD || r_state == dtq_pkg::S_INS_CMP)
            |-> (r_count < CW'(QUEUE_DEPTH)))
        else $error("insert started on a full queue");

    // No fired entry is left behind when the block goes idle
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtq_pkg::S_IDLE) |-> !r_pend_valid)
        else $error("fired entry lost at end of item");

    // Only fired beats may be non-last
    a_last_nonfired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != dtq_pkg::ST_FIRED) |-> r_out_last)
        else $error("non-fired result without last");

endmodule

// ----- sv/dtq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/dtq_alu.sv -----
// Shared arithmetic unit: saturating 48-bit add and unsigned less-than.
module dtq_alu (
    input  logic [dtq_pkg::TIME_W-1:0] i_a,
    input  logic [dtq_pkg::TIME_W-1:0] i_b,
    output logic [dtq_pkg::TIME_W-1:0] o_sum,
    output logic                       o_lt
);

    logic [dtq_pkg::TIME_W:0] w_sum;

    // Add with carry out, clamp on overflow
    assign w_sum = {1'b0, i_a} + {1'b0, i_b};
    assign o_sum = w_sum[dtq_pkg::TIME_W] ? dtq_pkg::TIME_MAX : w_sum[dtq_pkg::TIME_W-1:0];

    // Strict unsigned compare
    assign o_lt = (i_a < i_b);

endmodule

// ----- tb/sv/tb_deadline_timer_queue.sv -----
// Self-checking testbench for the deadline timer queue: directed, queue-full, random and large-step tests.
module tb_deadline_timer_queue;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 32;
    localparam int TIME_W   = dtq_pkg::TIME_W;
    localparam int TAG_W    = dtq_pkg::TAG_W;
    localparam int ARG_W    = dtq_pkg::ARG_W;
    localparam int STATUS_W = dtq_pkg::STATUS_W;

    // One result beat as the block reports it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   deadline;
        logic                is_last;
    } t_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [79:0] i_s_tdata;   // delay[31:0], tag[47:32], step[79:48]
    logic        i_s_tuser;   // func
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;   // status[1:0], fired_tag[17:2], fired_deadline[65:18], zero
    logic        o_m_tlast;

    // Own copy of the timer queue: time counter and deadline-sorted entries
    logic [TIME_W-1:0] now_time = '0;
    logic [TIME_W-1:0] slot_deadline [DEPTH];
    logic [TAG_W-1:0]  slot_tag [DEPTH];
    int                slot_count = 0;

    // Results still owed by the block, oldest first
    t_report awaited_reports[$];

    int sender_idle_pct    = 19;
    int receiver_stall_pct = 19;
    int mismatch_count     = 0;

    deadline_timer_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Append one owed beat at the tail
    function automatic void owe_report(t_report rep);
        awaited_reports.insert(awaited_reports.size(), rep);
    endfunction

    // Apply one accepted item to the local queue and queue up the beats it owes
    function automatic void timer_queue_update(logic func, logic [ARG_W-1:0] delay,
                                               logic [TAG_W-1:0] tag, logic [ARG_W-1:0] step);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] due;
        int                pos;
        int                fired;
        t_report           rep;
        rep = '0;
        rep.is_last = 1'b1;
        if (func == dtq_pkg::FUNC_SCHEDULE) begin
            sum = now_time + delay;
            due = (sum > dtq_pkg::TIME_MAX) ? dtq_pkg::TIME_MAX : sum[TIME_W-1:0];
            if (slot_count < DEPTH) begin
                // Insert behind every entry with an equal or earlier deadline
                pos = slot_count;
                while (pos > 0 && slot_deadline[pos-1] > due) begin
                    slot_deadline[pos] = slot_deadline[pos-1];
                    slot_tag[pos]      = slot_tag[pos-1];
                    pos--;
                end
                slot_deadline[pos] = due;
                slot_tag[pos]      = tag;
                slot_count++;
                rep.status = dtq_pkg::ST_SCHEDULED;
            end else begin
                rep.status = dtq_pkg::ST_DROPPED;
            end
            owe_report(rep);
            return;
        end
        rep.status = dtq_pkg::ST_NONE;
        if (step == '0) begin
            owe_report(rep);
            return;
        end
        sum = now_time + step;
        now_time = (sum > dtq_pkg::TIME_MAX) ? dtq_pkg::TIME_MAX : sum[TIME_W-1:0];
        // Pop every entry that is strictly past due, earliest first
        fired = 0;
        while (fired < dtq_pkg::MAX_RESULTS && slot_count > 0 && slot_deadline[0] < now_time) begin
            rep.status   = dtq_pkg::ST_FIRED;
            rep.tag      = slot_tag[0];
            rep.deadline = slot_deadline[0];
            rep.is_last  = 1'b0;
            owe_report(rep);
            for (int i = 1; i < slot_count; i++) begin
                slot_deadline[i-1] = slot_deadline[i];
                slot_tag[i-1]      = slot_tag[i];
            end
            slot_count--;
            fired++;
        end
        if (fired == 0) begin
            rep = '0;
            rep.status  = dtq_pkg::ST_NONE;
            rep.is_last = 1'b1;
            owe_report(rep);
        end else begin
            // Mark the final fired beat as last
            rep = awaited_reports[awaited_reports.size() - 1];
            rep.is_last = 1'b1;
            awaited_reports[awaited_reports.size() - 1] = rep;
        end
    endfunction

    function automatic void flag_mismatch(string what, t_report want, t_report got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected status %0d tag %h deadline %h last %b,",
                     $realtime, what, want.status, want.tag, want.deadline, want.is_last);
            $display("    got status %0d tag %h deadline %h last %b",
                     got.status, got.tag, got.deadline, got.is_last);
        end
    endfunction

    // Random backpressure on the result stream
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Compare each result beat with the oldest owed one
    t_report got_rep;
    t_report want_rep;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_rep.status   = o_m_tdata[1:0];
            got_rep.tag      = o_m_tdata[17:2];
            got_rep.deadline = o_m_tdata[65:18];
            got_rep.is_last  = o_m_tlast;
            if (awaited_reports.size() == 0) begin
                flag_mismatch("unexpected beat", '0, got_rep);
            end else begin
                want_rep = awaited_reports.pop_front();
                if (got_rep.status !== want_rep.status || got_rep.tag !== want_rep.tag ||
                    got_rep.deadline !== want_rep.deadline ||
                    got_rep.is_last !== want_rep.is_last) begin
                    flag_mismatch("mismatch", want_rep, got_rep);
                end
            end
        end
    end

    // Offer one item, hold it until accepted, then update the local queue
    task automatic send_item(logic func, logic [ARG_W-1:0] delay, logic [TAG_W-1:0] tag,
                             logic [ARG_W-1:0] step);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {step, tag, delay};
        do @(posedge i_clk); while (!o_s_tready);
        timer_queue_update(func, delay, tag, step);
    endtask

    // Unused fields carry random bits; the block must ignore them
    task automatic schedule_timeout(logic [ARG_W-1:0] delay, logic [TAG_W-1:0] tag);
        send_item(dtq_pkg::FUNC_SCHEDULE, delay, tag, ARG_W'($urandom));
    endtask

    task automatic advance_time(logic [ARG_W-1:0] step);
        send_item(dtq_pkg::FUNC_ADVANCE, ARG_W'($urandom), TAG_W'($urandom), step);
    endtask

    // Field extremes, equal deadlines, zero step and advances with nothing due
    task automatic test_directed;
        schedule_timeout(32'd0, 16'hFFFF);
        schedule_timeout(32'hFFFF_FFFF, 16'h0000);
        schedule_timeout(32'd5, 16'h1234);
        schedule_timeout(32'd5, 16'h4321);
        schedule_timeout(32'd2, 16'h00AA);
        advance_time(32'd0);
        advance_time(32'd1);
        advance_time(32'd1);
        advance_time(32'd2);
        advance_time(32'd2);
        advance_time(32'hFFFF_FFFF);
        advance_time(32'd3);
    endtask

    // Fill the queue, overflow it, then drain every entry with one advance
    task automatic test_queue_full;
        while (slot_count < DEPTH) begin
            schedule_timeout(ARG_W'($urandom_range(0, 7)), TAG_W'($urandom));
        end
        schedule_timeout(32'd0, 16'hFFFF);
        schedule_timeout(32'hFFFF_FFFF, TAG_W'($urandom));
        advance_time(32'd8);
        advance_time(32'd1);
    endtask

    // Mixed traffic across the idle and stall phases
    task automatic test_random_traffic;
        int idle_pct[4]  = '{0, 47, 0, 19};
        int stall_pct[4] = '{0, 0, 47, 19};
        int pick;
        int sel;
        logic [ARG_W-1:0] arg;
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = idle_pct[ph];
            receiver_stall_pct = stall_pct[ph];
            for (int n = 0; n < 65; n++) begin
                pick = $urandom_range(0, 99);
                sel  = $urandom_range(0, 9);
                if (pick < 55) begin
                    if (sel < 6) begin
                        arg = $urandom_range(0, 40);
                    end else if (sel < 8) begin
                        arg = $urandom_range(0, 1000);
                    end else if (sel == 8) begin
                        arg = $urandom;
                    end else begin
                        arg = ($urandom_range(0, 1) == 1) ? '1 : '0;
                    end
                    schedule_timeout(arg, TAG_W'($urandom));
                end else begin
                    if (sel == 0) begin
                        arg = '0;
                    end else if (sel < 7) begin
                        arg = $urandom_range(1, 30);
                    end else if (sel < 9) begin
                        arg = $urandom_range(1, 2000);
                    end else begin
                        arg = $urandom;
                    end
                    advance_time(arg);
                end
            end
        end
    endtask

    // Largest steps and delays, with deadlines just inside and just outside one step
    task automatic test_large_steps;
        sender_idle_pct    = 19;
        receiver_stall_pct = 19;
        schedule_timeout(32'hFFFF_FFFF, 16'hA5A5);
        schedule_timeout(32'hFFFF_FFFE, 16'h5A5A);
        advance_time(32'hFFFF_FFFF);
        schedule_timeout(32'hFFFF_FFFF, 16'hC3C3);
        schedule_timeout(32'd0, 16'h3C3C);
        advance_time(32'd1);
        advance_time(32'hFFFF_FFFF);
        advance_time(32'd1);
        advance_time(32'd0);
    endtask

    // Reset, run every test, drain and judge
    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= dtq_pkg::FUNC_SCHEDULE;
        i_s_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed;
        test_queue_full;
        test_random_traffic;
        test_large_steps;
        i_s_tvalid <= 1'b0;

        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/dtq_pkg.sv
sv/dtq_ram.sv
sv/dtq_alu.sv
sv/deadline_timer_queue.sv
tb/sv/tb_deadline_timer_queue.sv
